// File: rtl/rde_pkg.sv
// Shared types and constants for the reversible deque engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package rde_pkg;

   localparam int DEPTH_DEFAULT       = 64;
   localparam int VALUE_WIDTH_DEFAULT = 16;
   localparam int CMD_WIDTH           = 3;
   localparam int FIELD_WIDTH         = 16;
   localparam int STATUS_WIDTH        = 2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_CLEAR   = 3'd0,
      CMD_APPEND  = 3'd1,
      CMD_REVERSE = 3'd2,
      CMD_DELETE  = 3'd3,
      CMD_DUMP    = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      RSP_ELEMENT  = 2'd0,
      RSP_EMPTY    = 2'd1,
      RSP_ERROR    = 2'd2,
      RSP_OVERFLOW = 2'd3
   } rsp_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STATUS,
      ST_STREAM
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic op_clear;
      logic op_append;
      logic op_reverse;
      logic op_delete;
      logic dump_start;
      logic rd_issue;
      logic load_elem;
      logic load_status;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic dump_status;
      logic rd_done;
      logic out_free;
   } ctl_stat_type;

endpackage

// File: rtl/rde_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; instantiated by the datapath for the element store.
module rde_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rde_ctrl.sv
// Controller state machine of the reversible deque engine.
// Depends on rde_pkg; drives the datapath through ctl_cmd_type commands.
module rde_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rde_pkg::CMD_WIDTH-1:0]   req_cmd,
   input  rde_pkg::ctl_stat_type           stat,
   output rde_pkg::ctl_cmd_type            cmd
);
   import rde_pkg::*;

   state_type state_ff, state_in;
   logic      pending_ff, pending_in;
   logic      move;

   // A read result is pending when the RAM output holds an element not yet
   // moved into the output register.
   always_comb begin
      cmd        = '0;
      req_ready  = (state_ff == ST_IDLE);
      move       = pending_ff && stat.out_free;
      pending_in = pending_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_CLEAR:   cmd.op_clear   = 1'b1;
                  CMD_APPEND:  cmd.op_append  = 1'b1;
                  CMD_REVERSE: cmd.op_reverse = 1'b1;
                  CMD_DELETE:  cmd.op_delete  = 1'b1;
                  CMD_DUMP:    cmd.dump_start = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_STATUS: begin
            cmd.load_status = stat.out_free;
         end
         ST_STREAM: begin
            cmd.load_elem = move;
            cmd.rd_issue  = !stat.rd_done && (!pending_ff || move);
            if (cmd.rd_issue) begin
               pending_in = 1'b1;
            end else if (move) begin
               pending_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_cmd == CMD_DUMP) begin
               state_in = stat.dump_status ? ST_STATUS : ST_STREAM;
            end
         end
         ST_STATUS: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_STREAM: begin
            if (stat.rd_done && (!pending_ff || stat.out_free)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// File: rtl/rde_dpath.sv
// Datapath of the reversible deque engine: pointers, flags, dump read
// counter, element store and output register. Depends on rde_pkg and rde_ram.
module rde_dpath #(
   parameter int DEPTH       = rde_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = rde_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rde_pkg::ctl_cmd_type              cmd,
   output rde_pkg::ctl_stat_type             stat,
   input  logic [rde_pkg::FIELD_WIDTH-1:0]   req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rde_pkg::FIELD_WIDTH-1:0]   rsp_element,
   output logic [rde_pkg::STATUS_WIDTH-1:0]  rsp_status,
   output logic                              rsp_last
);
   import rde_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;

   logic [AW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rev_ff, rev_in;
   logic                   err_ff, err_in;
   logic                   ovf_ff, ovf_in;
   logic [CW-1:0]          rd_i_ff, rd_i_in;
   logic                   rd_last_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [FIELD_WIDTH-1:0] out_elem_ff;
   rsp_status_type         out_status_ff;
   logic                   out_last_ff;

   logic                   full;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;
   logic [CW-1:0]          rd_off;
   logic [31:0]            value_ext;
   logic [31:0]            rd_ext;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [VALUE_WIDTH-1:0] rd_data;

   // Physical slot of a logical offset from the head; the sum stays below
   // twice the depth, so one compare and subtract wraps it.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [SW-1:0] off);
      logic [SW-1:0] s;
      s = SW'(head) + off;
      if (s >= SW'(DEPTH)) begin
         s = s - SW'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   assign full      = (count_ff == CW'(DEPTH));
   assign value_ext = 32'(req_value);
   assign wr_data   = value_ext[VALUE_WIDTH-1:0];
   assign wr_en     = cmd.op_append && !full;
   assign wr_addr   = slot_of(head_ff, SW'(count_ff));
   assign rd_off    = rev_ff ? (count_ff - rd_i_ff - CW'(1)) : rd_i_ff;
   assign rd_addr   = slot_of(head_ff, SW'(rd_off));
   assign rd_ext    = 32'(rd_data);

   rde_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      rev_in   = rev_ff;
      err_in   = err_ff;
      ovf_in   = ovf_ff;
      rd_i_in  = rd_i_ff;
      if (cmd.op_clear) begin
         head_in  = '0;
         count_in = '0;
         rev_in   = 1'b0;
         err_in   = 1'b0;
         ovf_in   = 1'b0;
      end
      if (cmd.op_append) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.op_reverse && !err_ff) begin
         rev_in = !rev_ff;
      end
      // While in error, a delete leaves everything as it is.
      if (cmd.op_delete && !err_ff) begin
         if (count_ff == '0) begin
            err_in = 1'b1;
         end else begin
            if (!rev_ff) begin
               head_in = slot_of(head_ff, SW'(1));
            end
            count_in = count_ff - CW'(1);
         end
      end
      if (cmd.dump_start) begin
         rd_i_in = '0;
      end else if (cmd.rd_issue) begin
         rd_i_in = rd_i_ff + CW'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_elem || cmd.load_status) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         err_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         rd_i_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         err_ff       <= err_in;
         ovf_ff       <= ovf_in;
         rd_i_ff      <= rd_i_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_last_ff <= ((rd_i_ff + CW'(1)) == count_ff);
      end
      if (cmd.load_elem) begin
         out_elem_ff   <= rd_ext[FIELD_WIDTH-1:0];
         out_status_ff <= RSP_ELEMENT;
         out_last_ff   <= rd_last_ff;
      end else if (cmd.load_status) begin
         out_elem_ff   <= '0;
         out_status_ff <= err_ff ? RSP_ERROR : (ovf_ff ? RSP_OVERFLOW : RSP_EMPTY);
         out_last_ff   <= 1'b1;
      end
   end

   assign stat.dump_status = err_ff || ovf_ff || (count_ff == '0);
   assign stat.rd_done     = (rd_i_ff == count_ff);
   assign stat.out_free    = !out_valid_ff || rsp_ready;

   assign rsp_valid   = out_valid_ff;
   assign rsp_element = out_elem_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_last    = out_last_ff;

endmodule

// File: rtl/reversible_deque_engine_top.sv
// Top level of the reversible deque engine: joins controller and datapath.
// Depends on rde_pkg, rde_ctrl, rde_dpath and, below it, rde_ram.
//
//   Channel   Ports                                   Direction
//   request   req_valid/ready, req_cmd, req_value     in
//   response  rsp_valid/ready, rsp_element/status/last out
//
// Clear, append, reverse and delete are accepted back to back. A dump of N
// elements streams one element a cycle from the store's registered read port
// while the response is not stalled. No request is taken during a dump.
// Reset is synchronous and clears pointers, flags and the controller; the
// store is not cleared. A stalled response holds in the output register.
module reversible_deque_engine_top #(
   parameter int DEPTH       = rde_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = rde_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rde_pkg::CMD_WIDTH-1:0]     req_cmd,
   input  logic [rde_pkg::FIELD_WIDTH-1:0]   req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rde_pkg::FIELD_WIDTH-1:0]   rsp_element,
   output logic [rde_pkg::STATUS_WIDTH-1:0]  rsp_status,
   output logic                              rsp_last
);
   import rde_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   rde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .stat      (stat),
      .cmd       (cmd)
   );

   rde_dpath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_element (rsp_element),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last)
   );

endmodule

// File: tb/sv/reversible_deque_engine_top_tb.sv
// Self-checking bench for reversible_deque_engine_top: drives command transfers,
// predicts each dump response with a behavioural deque or a scripted status and checks each one.
// Depends on rde_pkg and the engine RTL; reads no files.
`timescale 1ns / 1ps

module reversible_deque_engine_top_tb;
   import rde_pkg::*;

   localparam int SLOTS       = DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int SCRIPT_LEN  = 27;
   localparam int AWAIT_SLOTS = 256;

   // Command codes outside the decoded set; the engine must ignore them.
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] element;
      rsp_status_type         status;
      logic                   last;
   } dump_word_type;

   typedef struct {
      logic [CMD_WIDTH-1:0]   cmd;
      logic [FIELD_WIDTH-1:0] value;
      bit                     typed;
      rsp_status_type         status;
   } script_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [CMD_WIDTH-1:0]     req_cmd;
   logic [FIELD_WIDTH-1:0]   req_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [FIELD_WIDTH-1:0]   rsp_element;
   logic [STATUS_WIDTH-1:0]  rsp_status;
   logic                     rsp_last;

   // Shadow copy of the deque state.
   logic [FIELD_WIDTH-1:0]   shadow_store [SLOTS];
   logic [5:0]               shadow_head;
   logic [6:0]               shadow_count;
   bit                       shadow_rev;
   bit                       shadow_err;
   bit                       shadow_ovf;

   dump_word_type            step_words [SLOTS];
   int                       step_len;
   // Expected responses in order; a ring indexed by running write and read counts.
   dump_word_type            awaited_words [AWAIT_SLOTS];
   int                       awaited_wr;
   int                       awaited_rd;

   int                       send_idle_pct;
   int                       recv_idle_pct;
   int                       mismatches;
   int                       sent;
   int                       quiet_cycles;

   // Rows with a typed status are dumps whose answer is obvious; the rest use the shadow deque.
   script_row_type script [SCRIPT_LEN] = '{
      '{CMD_DUMP,    16'h0000, 1'b1, RSP_EMPTY},
      '{CMD_DELETE,  16'h0000, 1'b0, RSP_ELEMENT},
      '{CMD_DUMP,    16'hFFFF, 1'b1, RSP_ERROR},
      '{CMD_REVERSE, 16'h0000, 1'b0, RSP_ELEMENT},
      '{CMD_APPEND,  16'hFFFF, 1'b0, RSP_ELEMENT},
      '{CMD_DELETE,  16'h0000, 1'b0, RSP_ELEMENT},
      '{CMD_DUMP,    16'h0000, 1'b1, RSP_ERROR},
      '{CMD_CLEAR,   16'hFFFF, 1'b0, RSP_ELEMENT},
      '{CMD_DUMP,    16'h0000, 1'b1, RSP_EMPTY},
      '{CMD_APPEND,  16'h0000, 1'b0, RSP_ELEMENT},
      '{CMD_APPEND,  16'hFFFF, 1'b0, RSP_ELEMENT},
      '{CMD_APPEND,  16'hA5C3, 1'b0, RSP_ELEMENT},
      '{CMD_DUMP,    16'h0000, 1'b0, RSP_ELEMENT},
      '{CMD_REVERSE, 16'hFFFF, 1'b0, RSP_ELEMENT},
      '{CMD_DUMP,    16'h0000, 1'b0, RSP_ELEMENT},
      '{CMD_DELETE,  16'h0000, 1'b0, RSP_ELEMENT},
      '{CMD_DUMP,    16'h0000, 1'b0, RSP_ELEMENT},
      '{CMD_SPARE_5, 16'h5A3C, 1'b0, RSP_ELEMENT},
      '{CMD_SPARE_6, 16'hFFFF, 1'b0, RSP_ELEMENT},
      '{CMD_SPARE_7, 16'h0000, 1'b0, RSP_ELEMENT},
      '{CMD_DUMP,    16'h0000, 1'b0, RSP_ELEMENT},
      '{CMD_REVERSE, 16'h0000, 1'b0, RSP_ELEMENT},
      '{CMD_DELETE,  16'h0000, 1'b0, RSP_ELEMENT},
      '{CMD_APPEND,  16'h1234, 1'b0, RSP_ELEMENT},
      '{CMD_DUMP,    16'h0000, 1'b0, RSP_ELEMENT},
      '{CMD_CLEAR,   16'h0000, 1'b0, RSP_ELEMENT},
      '{CMD_DUMP,    16'h0000, 1'b1, RSP_EMPTY}
   };

   reversible_deque_engine_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_element (rsp_element),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [5:0] slot_at(input logic [6:0] offset);
      logic [5:0] slot;
      slot = shadow_head + offset[5:0];
      return slot;
   endfunction

   function automatic void step_add(input dump_word_type w);
      step_words[step_len] = w;
      step_len++;
   endfunction

   function automatic void await_add(input dump_word_type w);
      awaited_words[awaited_wr % AWAIT_SLOTS] = w;
      awaited_wr++;
   endfunction

   function automatic dump_word_type await_take();
      dump_word_type w;
      w = awaited_words[awaited_rd % AWAIT_SLOTS];
      awaited_rd++;
      return w;
   endfunction

   function automatic int await_level();
      return awaited_wr - awaited_rd;
   endfunction

   // Applies one command to the shadow deque and leaves its dump words in step_words.
   function automatic void deque_step(input logic [CMD_WIDTH-1:0] c,
                                      input logic [FIELD_WIDTH-1:0] v);
      logic [6:0] off;
      dump_word_type w;
      step_len = 0;
      case (c)
         CMD_CLEAR: begin
            shadow_head  = '0;
            shadow_count = '0;
            shadow_rev   = 1'b0;
            shadow_err   = 1'b0;
            shadow_ovf   = 1'b0;
         end
         CMD_APPEND: begin
            if (shadow_count >= SLOTS) begin
               shadow_ovf = 1'b1;
            end else begin
               shadow_store[slot_at(shadow_count)] = v;
               shadow_count = shadow_count + 7'd1;
            end
         end
         CMD_REVERSE: begin
            if (!shadow_err) shadow_rev = !shadow_rev;
         end
         CMD_DELETE: begin
            if (!shadow_err) begin
               if (shadow_count == 0) begin
                  shadow_err = 1'b1;
               end else begin
                  if (!shadow_rev) shadow_head = slot_at(7'd1);
                  shadow_count = shadow_count - 7'd1;
               end
            end
         end
         CMD_DUMP: begin
            if (shadow_err) begin
               w = '{16'h0000, RSP_ERROR, 1'b1};
               step_add(w);
            end else if (shadow_ovf) begin
               w = '{16'h0000, RSP_OVERFLOW, 1'b1};
               step_add(w);
            end else if (shadow_count == 0) begin
               w = '{16'h0000, RSP_EMPTY, 1'b1};
               step_add(w);
            end else begin
               for (int i = 0; i < shadow_count; i++) begin
                  off = shadow_rev ? 7'(shadow_count - 1 - i) : 7'(i);
                  w.element = shadow_store[slot_at(off)];
                  w.status  = RSP_ELEMENT;
                  w.last    = (i + 1 == shadow_count);
                  step_add(w);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_cmd(input logic [CMD_WIDTH-1:0] c, input logic [FIELD_WIDTH-1:0] v,
                           input bit typed, input rsp_status_type st);
      dump_word_type w;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= c;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      deque_step(c, v);
      if (typed) begin
         w = '{16'h0000, st, 1'b1};
         await_add(w);
      end else begin
         for (int k = 0; k < step_len; k++) await_add(step_words[k]);
      end
      sent++;
   endtask

   task automatic issue(input logic [CMD_WIDTH-1:0] c);
      send_cmd(c, 16'($urandom), 1'b0, RSP_ELEMENT);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (await_level() != 0) @(posedge clock);
   endtask

   // Most sequences build, reverse or shrink a queue and dump it; the rest cover clearing, error, overflow and noise.
   task automatic random_phase(input int budget, input bit force_fill, input bit drain);
      int start;
      int seq;
      int kind;
      int n;
      int pick;
      start = sent;
      seq   = 0;
      while (sent - start < budget) begin
         kind = $urandom_range(99);
         if (force_fill && seq == 1) kind = 99;
         seq++;
         if (kind < 35) begin
            n = $urandom_range(6, 1);
            repeat (n) issue(CMD_APPEND);
            issue(CMD_DUMP);
         end else if (kind < 50) begin
            issue(CMD_REVERSE);
            n = $urandom_range(2);
            repeat (n) issue(CMD_APPEND);
            issue(CMD_DUMP);
         end else if (kind < 65) begin
            n = $urandom_range(3, 1);
            repeat (n) issue(CMD_DELETE);
            issue(CMD_DUMP);
         end else if (kind < 72) begin
            issue(CMD_CLEAR);
            if ($urandom_range(1) == 1) issue(CMD_DUMP);
         end else if (kind < 82) begin
            if (shadow_count > 8) issue(CMD_CLEAR);
            while (!shadow_err) issue(CMD_DELETE);
            n = $urandom_range(3, 1);
            repeat (n) begin
               pick = $urandom_range(2);
               if (pick == 0) issue(CMD_APPEND);
               else if (pick == 1) issue(CMD_REVERSE);
               else issue(CMD_DELETE);
            end
            issue(CMD_DUMP);
            if ($urandom_range(9) < 7) issue(CMD_CLEAR);
         end else if (kind < 94) begin
            n = $urandom_range(4, 1);
            repeat (n) send_cmd(3'($urandom_range(7)), 16'($urandom), 1'b0, RSP_ELEMENT);
            issue(CMD_DUMP);
         end else begin
            // Start with the head moved off slot zero so that the full queue wraps.
            issue(CMD_CLEAR);
            repeat (5) issue(CMD_APPEND);
            repeat (3) issue(CMD_DELETE);
            while (shadow_count < SLOTS) issue(CMD_APPEND);
            issue(CMD_DUMP);
            issue(CMD_REVERSE);
            issue(CMD_DUMP);
            issue(CMD_APPEND);
            issue(CMD_DUMP);
            if (drain) begin
               // Emptying and then deleting once more leaves both sticky flags set.
               while (shadow_count != 0) issue(CMD_DELETE);
               issue(CMD_DELETE);
               issue(CMD_DUMP);
            end
            issue(CMD_CLEAR);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      dump_word_type got;
      dump_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.element = rsp_element;
         got.status  = rsp_status_type'(rsp_status);
         got.last    = rsp_last;
         if (await_level() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with nothing outstanding: element %h status %0d last %b",
                        $time, got.element, got.status, got.last);
         end else begin
            want = await_take();
            if (got.element !== want.element || got.status !== want.status ||
                got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: expected element %h status %0d last %b, got %h %0d %b",
                           $time, want.element, want.status, want.last,
                           got.element, got.status, got.last);
            end
         end
      end
   end

   // Any transfer on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_cmd      <= CMD_CLEAR;
      req_value    <= '0;
      rsp_ready    <= 1'b0;
      quiet_cycles <= 0;
      mismatches    = 0;
      sent          = 0;
      awaited_wr    = 0;
      awaited_rd    = 0;
      step_len      = 0;
      send_idle_pct = 14;
      recv_idle_pct = 80;
      shadow_head   = '0;
      shadow_count  = '0;
      shadow_rev    = 1'b0;
      shadow_err    = 1'b0;
      shadow_ovf    = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[r])
         send_cmd(script[r].cmd, script[r].value, script[r].typed, script[r].status);
      random_phase(50, 1'b0, 1'b0);
      wait_drained();

      send_idle_pct = 80;
      recv_idle_pct = 14;
      random_phase(30, 1'b0, 1'b0);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(20, 1'b1, 1'b1);
      wait_drained();

      repeat (10) @(posedge clock);
      if (mismatches == 0 && await_level() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/rde_pkg.sv
rtl/rde_ram.sv
rtl/rde_ctrl.sv
rtl/rde_dpath.sv
rtl/reversible_deque_engine_top.sv
tb/sv/reversible_deque_engine_top_tb.sv
